>>> rtl/core/lightning_event_classify_log_top_macros.svh
// assertion helpers used by the checker file
`ifndef LIGHTNING_EVENT_CLASSIFY_LOG_TOP_MACROS_SVH
`define LIGHTNING_EVENT_CLASSIFY_LOG_TOP_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define LECL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define LECL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lecl_pkg.sv
`default_nettype none
package lecl_pkg;

    localparam int HISTORY_DEPTH = 128;
    localparam int QIDX_W        = 7;

    // request actions
    localparam logic [1:0] ACT_CLASSIFY = 2'd0;
    localparam logic [1:0] ACT_NTH_ANY  = 2'd1;
    localparam logic [1:0] ACT_NTH_THDR = 2'd2;
    localparam logic [1:0] ACT_NTH_FALSE = 2'd3;

    // signal classes
    localparam logic [1:0] CLS_NONE    = 2'd0;
    localparam logic [1:0] CLS_VALID   = 2'd1;
    localparam logic [1:0] CLS_INVALID = 2'd2;
    localparam logic [1:0] CLS_CLEARED = 2'd3;

    // event kinds
    localparam logic [2:0] KIND_EMPTY     = 3'd0;
    localparam logic [2:0] KIND_THUNDER   = 3'd1;
    localparam logic [2:0] KIND_TOOFAR    = 3'd2;
    localparam logic [2:0] KIND_NODIST    = 3'd3;
    localparam logic [2:0] KIND_DISTURBER = 3'd4;
    localparam logic [2:0] KIND_NOISE     = 3'd5;

    // interrupt source bits
    localparam int SRC_LIGHTNING = 3;
    localparam int SRC_DISTURBER = 1;
    localparam int SRC_NOISE     = 0;

    localparam logic [7:0] DIST_FAR = 8'h3F;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  int_source;
        logic [7:0]  distance_raw;
        logic [7:0]  energy_low;
        logic [7:0]  energy_mid;
        logic [7:0]  energy_high;
        logic [31:0] stamp;
        logic [6:0]  query_index;
    } t_req;

    typedef struct packed {
        logic        found;
        logic [1:0]  signal_class;
        logic [2:0]  event_kind;
        logic [7:0]  event_distance;
        logic [19:0] event_energy;
        logic [31:0] event_stamp;
    } t_rsp;

    // classified command handed from front to back
    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  signal_class;
        logic [2:0]  kind;
        logic [7:0]  distance;
        logic [19:0] energy;
        logic [31:0] stamp;
        logic [6:0]  query_index;
    } t_cmd;

    // one history record
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  distance;
        logic [19:0] energy;
        logic [31:0] stamp;
    } t_entry;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } t_back_state;

endpackage
`default_nettype wire

>>> rtl/core/lightning_event_classify_log_top.sv
// classify request: queued, then its result is registered when the queue and the
//   result register are free; one classify per cycle sustained with results taken at once
// query request: the history is scanned newest first, one entry per cycle; the result is
//   registered on a hit, or on a miss once all logged entries are read (none when empty)
// reset (synchronous, active low) clears config, queue, write pointer, count and output
//   valid; history memory not cleared, no clearing pass, requests are taken right away
`default_nettype none
module lightning_event_classify_log_top #(
    parameter int HISTORY_DEPTH = lecl_pkg::HISTORY_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // configuration: distance masking bit
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_wdata,
    // request channel
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire lecl_pkg::t_req i_in_req,
    // result channel
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output lecl_pkg::t_rsp      o_out_rsp
);

    // front to queue
    logic           push;
    lecl_pkg::t_cmd front_cmd;
    logic           q_full;

    // queue to back
    logic           q_valid;
    logic           q_pop;
    lecl_pkg::t_cmd back_cmd;

    // front: holds the mask register, decodes the source nibble by priority
    // (lightning over disturber over noise) and grades the distance
    lecl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    // two-entry queue so the front keeps taking requests while a query scan runs
    lecl_fifo #(
        .WIDTH ($bits(lecl_pkg::t_cmd))
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rdata (back_cmd),
        .i_pop   (q_pop)
    );

    // back: logs events into the ring history, scans it newest first for queries,
    // and owns the result register
    lecl_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (back_cmd),
        .o_cmd_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

endmodule
`default_nettype wire

>>> rtl/core/lecl_ram.sv
`default_nettype none
module lecl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> rtl/core/lecl_fifo.sv
`default_nettype none
module lecl_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_rdata,
    input  wire logic             i_pop
);

    // two-entry queue
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_rdata = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/lecl_front.sv
`default_nettype none
module lecl_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_wdata,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire lecl_pkg::t_req i_in_req,
    input  wire logic          i_q_full,
    output logic               o_push,
    output lecl_pkg::t_cmd     o_cmd
);

    logic       r_mask;
    logic [7:0] dist_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= 1'b0;
        end else if (i_cfg_we) begin
            r_mask <= i_cfg_wdata;
        end
    end

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    assign dist_eff = r_mask ? {2'b00, i_in_req.distance_raw[5:0]} : i_in_req.distance_raw;

    always_comb begin
        o_cmd              = '0;
        o_cmd.action       = i_in_req.action;
        o_cmd.query_index  = i_in_req.query_index;
        if (i_in_req.action == lecl_pkg::ACT_CLASSIFY) begin
            if (i_in_req.int_source[lecl_pkg::SRC_LIGHTNING]) begin
                if (dist_eff != 8'd0 && dist_eff < lecl_pkg::DIST_FAR) begin
                    o_cmd.kind         = lecl_pkg::KIND_THUNDER;
                    o_cmd.signal_class = lecl_pkg::CLS_VALID;
                end else begin
                    o_cmd.kind = (dist_eff >= lecl_pkg::DIST_FAR) ? lecl_pkg::KIND_TOOFAR
                                                                  : lecl_pkg::KIND_NODIST;
                    o_cmd.signal_class = lecl_pkg::CLS_INVALID;
                end
                o_cmd.distance = dist_eff;
                o_cmd.energy   = {i_in_req.energy_high[3:0], i_in_req.energy_mid,
                                  i_in_req.energy_low};
                o_cmd.stamp    = i_in_req.stamp;
            end else if (i_in_req.int_source[lecl_pkg::SRC_DISTURBER]) begin
                o_cmd.kind         = lecl_pkg::KIND_DISTURBER;
                o_cmd.signal_class = lecl_pkg::CLS_INVALID;
                o_cmd.stamp        = i_in_req.stamp;
            end else if (i_in_req.int_source[lecl_pkg::SRC_NOISE]) begin
                o_cmd.kind         = lecl_pkg::KIND_NOISE;
                o_cmd.signal_class = lecl_pkg::CLS_INVALID;
                o_cmd.stamp        = i_in_req.stamp;
            end else if (i_in_req.int_source == 4'd0) begin
                o_cmd.signal_class = lecl_pkg::CLS_CLEARED;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/lecl_back.sv
`default_nettype none
module lecl_back #(
    parameter int HISTORY_DEPTH = lecl_pkg::HISTORY_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_valid,
    input  wire lecl_pkg::t_cmd i_cmd,
    output logic                o_cmd_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output lecl_pkg::t_rsp      o_out_rsp
);

    localparam int AW   = $clog2(HISTORY_DEPTH);
    localparam int CW   = $clog2(HISTORY_DEPTH + 1);
    localparam int CMPW = (CW > lecl_pkg::QIDX_W) ? CW : lecl_pkg::QIDX_W;
    localparam int EW   = $bits(lecl_pkg::t_entry);

    lecl_pkg::t_back_state r_state, n_state;
    logic [AW-1:0]         r_wp, n_wp;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]         r_issued, n_issued;
    logic [CW-1:0]         r_hits, n_hits;
    logic                  r_pend, n_pend;
    logic [1:0]            r_action, n_action;
    logic [6:0]            r_qidx, n_qidx;
    logic                  r_out_valid, n_out_valid;
    lecl_pkg::t_rsp        r_out, n_out;

    logic                  ram_we;
    lecl_pkg::t_entry      wr_entry;
    logic [EW-1:0]         ram_rdata;
    lecl_pkg::t_entry      rd_entry;
    logic                  out_free;
    logic                  match;
    logic                  hit;

    lecl_ram #(
        .WIDTH (EW),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (wr_entry),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = ram_rdata;
    assign wr_entry = '{kind: i_cmd.kind, distance: i_cmd.distance,
                        energy: i_cmd.energy, stamp: i_cmd.stamp};

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        case (r_action)
            lecl_pkg::ACT_NTH_ANY:  match = 1'b1;
            lecl_pkg::ACT_NTH_THDR: match = (rd_entry.kind == lecl_pkg::KIND_THUNDER);
            default:                match = (rd_entry.kind != lecl_pkg::KIND_THUNDER);
        endcase
    end

    assign hit = r_pend && match && (CMPW'(r_hits) == CMPW'(r_qidx));

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_count     = r_count;
        n_rd_ptr    = r_rd_ptr;
        n_issued    = r_issued;
        n_hits      = r_hits;
        n_pend      = 1'b0;
        n_action    = r_action;
        n_qidx      = r_qidx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        ram_we      = 1'b0;
        case (r_state)
            lecl_pkg::BK_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.action == lecl_pkg::ACT_CLASSIFY) begin
                        n_out_valid          = 1'b1;
                        n_out.found          = (i_cmd.kind != lecl_pkg::KIND_EMPTY);
                        n_out.signal_class   = i_cmd.signal_class;
                        n_out.event_kind     = i_cmd.kind;
                        n_out.event_distance = i_cmd.distance;
                        n_out.event_energy   = i_cmd.energy;
                        n_out.event_stamp    = i_cmd.stamp;
                        if (i_cmd.kind != lecl_pkg::KIND_EMPTY) begin
                            ram_we = 1'b1;
                            n_wp   = (r_wp == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                            if (r_count != CW'(HISTORY_DEPTH)) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                    end else begin
                        // newest entry sits just behind the write slot
                        n_rd_ptr = (r_wp == '0) ? AW'(HISTORY_DEPTH - 1) : r_wp - 1'b1;
                        n_issued = '0;
                        n_hits   = '0;
                        n_action = i_cmd.action;
                        n_qidx   = i_cmd.query_index;
                        n_state  = lecl_pkg::BK_SCAN;
                    end
                end
            end
            lecl_pkg::BK_SCAN: begin
                if (hit) begin
                    n_out_valid          = 1'b1;
                    n_out.found          = 1'b1;
                    n_out.signal_class   = lecl_pkg::CLS_NONE;
                    n_out.event_kind     = rd_entry.kind;
                    n_out.event_distance = rd_entry.distance;
                    n_out.event_energy   = rd_entry.energy;
                    n_out.event_stamp    = rd_entry.stamp;
                    n_state              = lecl_pkg::BK_IDLE;
                end else if (!r_pend && r_issued == r_count) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_state     = lecl_pkg::BK_IDLE;
                end else begin
                    if (r_pend && match) begin
                        n_hits = r_hits + 1'b1;
                    end
                    if (r_issued != r_count) begin
                        n_pend   = 1'b1;
                        n_issued = r_issued + 1'b1;
                        n_rd_ptr = (r_rd_ptr == '0) ? AW'(HISTORY_DEPTH - 1) : r_rd_ptr - 1'b1;
                    end
                end
            end
            default: begin
                n_state = lecl_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lecl_pkg::BK_IDLE;
            r_wp        <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr <= n_rd_ptr;
        r_issued <= n_issued;
        r_hits   <= n_hits;
        r_action <= n_action;
        r_qidx   <= n_qidx;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule
`default_nettype wire

>>> rtl/core/lecl_checker.sv
`default_nettype none
`include "lightning_event_classify_log_top_macros.svh"
module lecl_checker (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           o_out_valid,
    input  wire logic           i_out_ready,
    input  wire lecl_pkg::t_rsp o_out_rsp
);

    // a stalled result stays offered
    `LECL_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")

    // a hit always carries a real event kind
    `LECL_ASSERT_IMP(a_found_kind, o_out_valid && o_out_rsp.found, o_out_rsp.event_kind != lecl_pkg::KIND_EMPTY, "found without event kind")

    // no hit means all event fields are zero
    `LECL_ASSERT_IMP(a_miss_zero, o_out_valid && !o_out_rsp.found, o_out_rsp.event_kind == lecl_pkg::KIND_EMPTY && o_out_rsp.event_distance == 8'd0 && o_out_rsp.event_energy == 20'd0 && o_out_rsp.event_stamp == 32'd0, "miss with nonzero fields")

    // valid signal class only for a logged thunder event
    `LECL_ASSERT_IMP(a_valid_thunder, o_out_valid && o_out_rsp.signal_class == lecl_pkg::CLS_VALID, o_out_rsp.found && o_out_rsp.event_kind == lecl_pkg::KIND_THUNDER, "valid class without thunder")

endmodule

bind lightning_event_classify_log_top lecl_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_rsp   (o_out_rsp)
);
`default_nettype wire

>>> test/tb_top.sv
`default_nettype none
module tb_top;
    import lecl_pkg::*;

    // readout source nibbles used by the directed rows
    localparam logic [3:0] SRC_CLEAR    = 4'h0;
    localparam logic [3:0] SRC_UNKNOWN  = 4'h4;
    localparam logic [3:0] SRC_LTG      = 4'h8;
    localparam logic [3:0] SRC_DIST     = 4'h2;
    localparam logic [3:0] SRC_NOISE_HI = 4'h1;
    localparam logic [3:0] SRC_ALL      = 4'hF;
    localparam logic [3:0] SRC_DIST_NS  = 4'h3;
    localparam logic [3:0] SRC_LTG_HI   = 4'hC;

    localparam int RAND_PER_PHASE = 100;
    localparam int RAND_PHASES    = 4;

    // directed row: request plus an optional hand-typed result
    typedef struct packed {
        t_req req;
        logic typed;
        t_rsp rsp;
    } dir_row_t;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_cfg_we    = 1'b0;
    logic i_cfg_wdata = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b0;
    t_req i_in_req    = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_rsp o_out_rsp;

    // shadow of the event history and the mask bit
    logic [2:0]  hist_kind   [HISTORY_DEPTH];
    logic [7:0]  hist_dist   [HISTORY_DEPTH];
    logic [19:0] hist_energy [HISTORY_DEPTH];
    logic [31:0] hist_stamp  [HISTORY_DEPTH];
    int          hist_wr  = 0;
    int          hist_cnt = 0;
    logic        mask_six = 1'b0;

    t_rsp     pending_rsp[$];
    dir_row_t dir_rows[$];
    int       errors = 0;
    bit       calm   = 1'b0;   // stretch with no idling on either side

    always #4 i_clk = ~i_clk;

    lightning_event_classify_log_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    function automatic t_req req_of(logic [1:0] act, logic [3:0] src, logic [7:0] dist_raw,
                                    logic [7:0] el, logic [7:0] em, logic [7:0] eh,
                                    logic [31:0] stamp, logic [6:0] qidx);
        t_req r;
        r.action       = act;
        r.int_source   = src;
        r.distance_raw = dist_raw;
        r.energy_low   = el;
        r.energy_mid   = em;
        r.energy_high  = eh;
        r.stamp        = stamp;
        r.query_index  = qidx;
        return r;
    endfunction

    function automatic t_rsp rsp_of(logic found, logic [1:0] cls, logic [2:0] kind,
                                    logic [7:0] ev_dist, logic [19:0] energy,
                                    logic [31:0] stamp);
        t_rsp p;
        p.found          = found;
        p.signal_class   = cls;
        p.event_kind     = kind;
        p.event_distance = ev_dist;
        p.event_energy   = energy;
        p.event_stamp    = stamp;
        return p;
    endfunction

    function automatic void add_row(t_req r, logic typed, t_rsp p);
        dir_row_t row;
        row.req   = r;
        row.typed = typed;
        row.rsp   = p;
        dir_rows.push_back(row);
    endfunction

    // classify a readout or answer a history query, updating the shadow history
    function automatic t_rsp classify_or_lookup(t_req r);
        t_rsp        p;
        logic [7:0]  eff_dist;
        logic [19:0] energy;
        int          hits;
        int          slot;
        bit          match;
        p    = '0;
        hits = 0;
        if (r.action == ACT_CLASSIFY) begin
            eff_dist = mask_six ? (r.distance_raw & 8'h3F) : r.distance_raw;
            energy   = {r.energy_high[3:0], r.energy_mid, r.energy_low};
            if (r.int_source[SRC_LIGHTNING]) begin
                if (eff_dist > 0 && eff_dist < DIST_FAR) begin
                    p.event_kind   = KIND_THUNDER;
                    p.signal_class = CLS_VALID;
                end else begin
                    p.event_kind   = (eff_dist >= DIST_FAR) ? KIND_TOOFAR : KIND_NODIST;
                    p.signal_class = CLS_INVALID;
                end
                p.event_distance = eff_dist;
                p.event_energy   = energy;
            end else if (r.int_source[SRC_DISTURBER]) begin
                p.event_kind   = KIND_DISTURBER;
                p.signal_class = CLS_INVALID;
            end else if (r.int_source[SRC_NOISE]) begin
                p.event_kind   = KIND_NOISE;
                p.signal_class = CLS_INVALID;
            end else if (r.int_source == 4'h0) begin
                p.signal_class = CLS_CLEARED;
            end
            if (p.event_kind != KIND_EMPTY) begin
                hist_kind[hist_wr]   = p.event_kind;
                hist_dist[hist_wr]   = p.event_distance;
                hist_energy[hist_wr] = p.event_energy;
                hist_stamp[hist_wr]  = r.stamp;
                hist_wr = (hist_wr + 1) % HISTORY_DEPTH;
                if (hist_cnt < HISTORY_DEPTH) hist_cnt++;
                p.found       = 1'b1;
                p.event_stamp = r.stamp;
            end
        end else begin
            for (int age = 0; age < hist_cnt; age++) begin
                slot = (hist_wr + HISTORY_DEPTH - 1 - age) % HISTORY_DEPTH;
                case (r.action)
                    ACT_NTH_ANY:  match = 1'b1;
                    ACT_NTH_THDR: match = (hist_kind[slot] == KIND_THUNDER);
                    default:      match = (hist_kind[slot] != KIND_THUNDER);
                endcase
                if (match) begin
                    if (hits == r.query_index) begin
                        if (hist_kind[slot] != KIND_EMPTY) begin
                            p.found          = 1'b1;
                            p.event_kind     = hist_kind[slot];
                            p.event_distance = hist_dist[slot];
                            p.event_energy   = hist_energy[slot];
                            p.event_stamp    = hist_stamp[slot];
                        end
                        break;
                    end
                    hits++;
                end
            end
        end
        return p;
    endfunction

    // random request, mostly well-formed readouts and queries near the logged count
    function automatic t_req random_req();
        t_req r;
        int   pick;
        int   lim;
        r = req_of(2'($urandom), 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), $urandom, 7'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            r.action = ACT_CLASSIFY;
            pick = $urandom_range(0, 99);
            if (pick < 50)      r.int_source = 4'($urandom_range(8, 15));
            else if (pick < 70) r.int_source = {1'b0, $urandom_range(0, 1) == 1, 1'b1,
                                                $urandom_range(0, 1) == 1};
            else if (pick < 85) r.int_source = {1'b0, $urandom_range(0, 1) == 1, 2'b01};
            else                r.int_source = ($urandom_range(0, 1) == 1) ? 4'h0 : 4'h4;
            pick = $urandom_range(0, 99);
            if (pick < 60)      r.distance_raw = 8'($urandom_range(1, 62));
            else if (pick < 75) r.distance_raw = 8'h00;
            else if (pick < 90) r.distance_raw = 8'($urandom_range(63, 255));
        end else begin
            r.action = 2'($urandom_range(1, 3));
            lim = (hist_cnt > 127) ? 127 : hist_cnt;
            pick = $urandom_range(0, 99);
            if (pick < 60)      r.query_index = 7'($urandom_range(0, lim));
            else if (pick < 85) r.query_index = 7'($urandom_range(0, 3));
        end
        return r;
    endfunction

    // offer one request after a random gap, then log what it should produce
    task automatic send_req(input t_req r, input logic typed, input t_rsp want);
        int   gap;
        t_rsp pred;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (!o_in_ready);
        pred = classify_or_lookup(r);
        pending_rsp.push_back(typed ? want : pred);
    endtask

    // mask write only once every result has drained
    task automatic set_mask(input logic v);
        i_in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mask_six = v;
    endtask

    task automatic check_rsp(input t_rsp got);
        t_rsp want;
        if (pending_rsp.size() == 0) begin
            $error("result with nothing expected: %h", got);
            errors++;
        end else begin
            want = pending_rsp.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, got.found);
                errors++;
            end
            if (got.signal_class !== want.signal_class) begin
                $error("signal_class: expected %0d, got %0d",
                       want.signal_class, got.signal_class);
                errors++;
            end
            if (got.event_kind !== want.event_kind) begin
                $error("event_kind: expected %0d, got %0d", want.event_kind, got.event_kind);
                errors++;
            end
            if (got.event_distance !== want.event_distance) begin
                $error("event_distance: expected %0d, got %0d",
                       want.event_distance, got.event_distance);
                errors++;
            end
            if (got.event_energy !== want.event_energy) begin
                $error("event_energy: expected %h, got %h",
                       want.event_energy, got.event_energy);
                errors++;
            end
            if (got.event_stamp !== want.event_stamp) begin
                $error("event_stamp: expected %h, got %h", want.event_stamp, got.event_stamp);
                errors++;
            end
        end
    endtask

    // result side: random stall per result, then hold ready until one is taken
    initial begin : result_sink
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            check_rsp(o_out_rsp);
        end
    end

    // hard stop if the run hangs
    initial begin : watchdog
        #4000000;
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        t_rsp nothing;
        nothing = '0;

        // queries on an empty history all miss
        add_row(req_of(ACT_NTH_ANY, 4'hF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 7'd0),
                1'b1, nothing);
        add_row(req_of(ACT_NTH_THDR, 4'h8, 8'h01, 8'h00, 8'h00, 8'h00, 32'h0, 7'd0),
                1'b1, nothing);
        add_row(req_of(ACT_NTH_FALSE, 4'h0, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 7'd127),
                1'b1, nothing);
        // statistics cleared and unknown source log nothing
        add_row(req_of(ACT_CLASSIFY, SRC_CLEAR, 8'h20, 8'h11, 8'h22, 8'h33, 32'h1234, 7'd5),
                1'b1, rsp_of(1'b0, CLS_CLEARED, KIND_EMPTY, 8'd0, 20'd0, 32'd0));
        add_row(req_of(ACT_CLASSIFY, SRC_UNKNOWN, 8'h20, 8'h11, 8'h22, 8'h33, 32'h5678, 7'd0),
                1'b1, nothing);
        // thunder range edges, too far, no distance; energy top nibble only
        add_row(req_of(ACT_CLASSIFY, SRC_LTG, 8'd1, 8'h01, 8'h00, 8'hF0, 32'h0, 7'd0),
                1'b1, rsp_of(1'b1, CLS_VALID, KIND_THUNDER, 8'd1, 20'h00001, 32'h0));
        add_row(req_of(ACT_CLASSIFY, SRC_LTG, 8'd62, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 7'd0),
                1'b1, rsp_of(1'b1, CLS_VALID, KIND_THUNDER, 8'd62, 20'hFFFFF, 32'hFFFF_FFFF));
        add_row(req_of(ACT_CLASSIFY, SRC_LTG, 8'd63, 8'h00, 8'h00, 8'h0F, 32'h1, 7'd0),
                1'b1, rsp_of(1'b1, CLS_INVALID, KIND_TOOFAR, 8'd63, 20'hF0000, 32'h1));
        add_row(req_of(ACT_CLASSIFY, SRC_LTG, 8'd255, 8'h34, 8'h12, 8'hA5, 32'h8000_0000, 7'd0),
                1'b1, rsp_of(1'b1, CLS_INVALID, KIND_TOOFAR, 8'd255, 20'h51234, 32'h8000_0000));
        add_row(req_of(ACT_CLASSIFY, SRC_LTG, 8'd0, 8'hAA, 8'h55, 8'h03, 32'h7FFF_FFFF, 7'd0),
                1'b1, rsp_of(1'b1, CLS_INVALID, KIND_NODIST, 8'd0, 20'h355AA, 32'h7FFF_FFFF));
        // disturber and noise drop distance and energy
        add_row(req_of(ACT_CLASSIFY, SRC_DIST, 8'd5, 8'hFF, 8'hFF, 8'hFF, 32'h0000_00A5, 7'd0),
                1'b1, rsp_of(1'b1, CLS_INVALID, KIND_DISTURBER, 8'd0, 20'd0, 32'h0000_00A5));
        add_row(req_of(ACT_CLASSIFY, SRC_NOISE_HI, 8'd9, 8'h12, 8'h34, 8'h05, 32'h5A5A_0000,
                       7'd0),
                1'b1, rsp_of(1'b1, CLS_INVALID, KIND_NOISE, 8'd0, 20'd0, 32'h5A5A_0000));
        // priority: lightning over disturber over noise
        add_row(req_of(ACT_CLASSIFY, SRC_ALL, 8'd10, 8'h00, 8'h80, 8'h00, 32'hCAFE_0001, 7'd0),
                1'b1, rsp_of(1'b1, CLS_VALID, KIND_THUNDER, 8'd10, 20'h08000, 32'hCAFE_0001));
        add_row(req_of(ACT_CLASSIFY, SRC_DIST_NS, 8'd10, 8'h01, 8'h02, 8'h03, 32'h2, 7'd0),
                1'b1, rsp_of(1'b1, CLS_INVALID, KIND_DISTURBER, 8'd0, 20'd0, 32'h2));
        add_row(req_of(ACT_CLASSIFY, SRC_LTG_HI, 8'd30, 8'h5A, 8'hA5, 8'h3C, 32'h3, 7'd0),
                1'b0, nothing);
        // lookups: newest, deeper, thunder only, non-thunder only, misses
        add_row(req_of(ACT_NTH_ANY, 4'h0, 8'h0, 8'h0, 8'h0, 8'h0, 32'h0, 7'd0), 1'b0, nothing);
        add_row(req_of(ACT_NTH_ANY, 4'h0, 8'h0, 8'h0, 8'h0, 8'h0, 32'h0, 7'd9), 1'b0, nothing);
        add_row(req_of(ACT_NTH_ANY, 4'h0, 8'h0, 8'h0, 8'h0, 8'h0, 32'h0, 7'd10), 1'b0, nothing);
        add_row(req_of(ACT_NTH_THDR, 4'h0, 8'h0, 8'h0, 8'h0, 8'h0, 32'h0, 7'd3), 1'b0, nothing);
        add_row(req_of(ACT_NTH_THDR, 4'h0, 8'h0, 8'h0, 8'h0, 8'h0, 32'h0, 7'd4), 1'b0, nothing);
        add_row(req_of(ACT_NTH_FALSE, 4'h0, 8'h0, 8'h0, 8'h0, 8'h0, 32'h0, 7'd0), 1'b0, nothing);
        add_row(req_of(ACT_NTH_FALSE, 4'h0, 8'h0, 8'h0, 8'h0, 8'h0, 32'h0, 7'd5), 1'b0, nothing);
        add_row(req_of(ACT_NTH_FALSE, 4'h0, 8'h0, 8'h0, 8'h0, 8'h0, 32'h0, 7'd127), 1'b0,
                nothing);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_mask(1'b0);

        foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

        // masked distance: high bits dropped before classification
        set_mask(1'b1);
        send_req(req_of(ACT_CLASSIFY, SRC_LTG, 8'h40, 8'h01, 8'h02, 8'h03, 32'h10, 7'd0),
                 1'b0, nothing);
        send_req(req_of(ACT_CLASSIFY, SRC_LTG, 8'hC1, 8'h04, 8'h05, 8'h06, 32'h11, 7'd0),
                 1'b0, nothing);
        send_req(req_of(ACT_CLASSIFY, SRC_LTG, 8'hFF, 8'h07, 8'h08, 8'h09, 32'h12, 7'd0),
                 1'b0, nothing);
        send_req(req_of(ACT_NTH_ANY, 4'h0, 8'h0, 8'h0, 8'h0, 8'h0, 32'h0, 7'd1), 1'b0, nothing);

        // random phases alternate the mask setting
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            set_mask(ph[0]);
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if (n % 25 == 0) calm = ($urandom_range(0, 3) == 0);
                send_req(random_req(), 1'b0, nothing);
            end
        end
        calm = 1'b0;

        // drain, then a little slack for any stray result
        i_in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
